[rtl/dvrt_pkg.sv]
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared types and constants of the distance-vector route table.
// ----------------------------------------------------------------------------
package dvrt_pkg;

    localparam int NODES_DEF     = 8;
    localparam int COST_BITS_DEF = 16;
    localparam int MISS_MAX      = 15;
    localparam int COUNT_MAX     = 65535;

    localparam logic [3:0] CMD_VECTOR = 4'd0;
    localparam logic [3:0] CMD_REMOTE = 4'd1;
    localparam logic [3:0] CMD_LOCAL  = 4'd2;
    localparam logic [3:0] CMD_ADD    = 4'd3;
    localparam logic [3:0] CMD_DIS    = 4'd4;
    localparam logic [3:0] CMD_CRASH  = 4'd5;
    localparam logic [3:0] CMD_TICK   = 4'd6;
    localparam logic [3:0] CMD_READ   = 4'd7;
    localparam logic [3:0] CMD_PKT    = 4'd8;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADID  = 2'd1;
    localparam logic [1:0] ST_NONBR  = 2'd2;
    localparam logic [1:0] ST_IGNORE = 2'd3;

    localparam logic REG_MY_ID      = 1'b0;
    localparam logic REG_MISS_LIMIT = 1'b1;

    // sweep kinds run by the datapath over table entries 1..NODES-1
    typedef enum logic [1:0] {
        SWP_DROP  = 2'd0,
        SWP_APPLY = 2'd1,
        SWP_TICK  = 2'd2
    } sweep_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SWEEP = 2'd1,
        S_OUT   = 2'd2
    } state_t;

    typedef struct packed {
        logic   start;  // item accepted: do single-beat work, latch it
        logic   sweep;  // process entry at index
        logic   last;   // final sweep step
    } ctl_t;

    typedef struct packed {
        logic   need_sweep;
        sweep_t kind;
    } sts_t;

endpackage

[rtl/dvrt_if.sv]
// ----------------------------------------------------------------------------
// dvrt_in_if / dvrt_out_if
// Valid/ready channels carrying command and result beats.
// ----------------------------------------------------------------------------
interface dvrt_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  cmd;
    logic [2:0]  sender_id;
    logic [2:0]  dest_id;
    logic [15:0] cost_value;
    logic        last_entry;
    modport source (output valid, cmd, sender_id, dest_id, cost_value, last_entry,
                    input ready);
    modport sink (input valid, cmd, sender_id, dest_id, cost_value, last_entry,
                  output ready);
endinterface

interface dvrt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  route_next_hop;
    logic [15:0] route_cost;
    logic [15:0] packet_count;
    logic [7:0]  timeout_mask;
    modport source (output valid, status, route_next_hop, route_cost, packet_count,
                    timeout_mask, input ready);
    modport sink (input valid, status, route_next_hop, route_cost, packet_count,
                  timeout_mask, output ready);
endinterface

[rtl/distance_vector_route_table_top.sv]
// ----------------------------------------------------------------------------
// distance_vector_route_table_top
// Distance-vector routing table engine for one network node.
// ----------------------------------------------------------------------------
// One command beat is taken at a time. Commands that need no walk offer
// their result beat right after acceptance; a vector's last entry, a tick,
// a disable, and an infinite remote or local cost walk entries 1..NODES-1
// one a cycle through the shared update unit before the result is offered.
// The next beat is accepted the cycle after the result beat is taken.
module distance_vector_route_table_top #(
    parameter int NODES     = dvrt_pkg::NODES_DEF,
    parameter int COST_BITS = dvrt_pkg::COST_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_idx,
    input  logic [3:0] cfg_data,
    dvrt_in_if.sink    in_ch,
    dvrt_out_if.source out_ch
);
    dvrt_pkg::ctl_t ctl;
    dvrt_pkg::sts_t sts;
    logic [$clog2(NODES)-1:0] idx;

    dvrt_ctrl #(.NODES(NODES)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .sts(sts), .ctl(ctl), .idx(idx)
    );

    dvrt_dp #(.NODES(NODES), .COST_BITS(COST_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .cmd(in_ch.cmd), .sender_id(in_ch.sender_id), .dest_id(in_ch.dest_id),
        .cost_value(in_ch.cost_value), .last_entry(in_ch.last_entry),
        .ctl(ctl), .idx(idx), .sts(sts),
        .status(out_ch.status), .route_next_hop(out_ch.route_next_hop),
        .route_cost(out_ch.route_cost), .packet_count(out_ch.packet_count),
        .timeout_mask(out_ch.timeout_mask)
    );
endmodule

[rtl/dvrt_ctrl.sv]
// ----------------------------------------------------------------------------
// dvrt_ctrl
// Sequencer: accepts a beat, walks the table when needed, holds the result.
// ----------------------------------------------------------------------------
module dvrt_ctrl #(
    parameter int NODES = dvrt_pkg::NODES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  dvrt_pkg::sts_t sts,
    output dvrt_pkg::ctl_t ctl,
    output logic [$clog2(NODES)-1:0] idx
);
    localparam int IW = $clog2(NODES);

    dvrt_pkg::state_t state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dvrt_pkg::S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            dvrt_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.start = 1'b1;
                    idx_next  = IW'(1);
                    state_next = sts.need_sweep ? dvrt_pkg::S_SWEEP : dvrt_pkg::S_OUT;
                end
            end
            dvrt_pkg::S_SWEEP:
            begin
                ctl.sweep = 1'b1;
                ctl.last  = (32'(idx_reg) == NODES - 1);
                idx_next  = idx_reg + IW'(1);
                if (ctl.last)
                    state_next = dvrt_pkg::S_OUT;
            end
            dvrt_pkg::S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = dvrt_pkg::S_IDLE;
            end
            default: state_next = dvrt_pkg::S_IDLE;
        endcase
    end

    assign idx = idx_reg;

    a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dvrt_pkg::S_SWEEP && ctl.last) |=> state_reg == dvrt_pkg::S_OUT)
        else $error("sweep did not end in result");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped");
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("accept while result pending");
endmodule

[rtl/dvrt_dp.sv]
// ----------------------------------------------------------------------------
// dvrt_dp
// Route table datapath: table registers, vector buffer, per-entry update unit.
// ----------------------------------------------------------------------------
module dvrt_dp #(
    parameter int NODES     = dvrt_pkg::NODES_DEF,
    parameter int COST_BITS = dvrt_pkg::COST_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           cfg_idx,
    input  logic [3:0]     cfg_data,
    input  logic [3:0]     cmd,
    input  logic [2:0]     sender_id,
    input  logic [2:0]     dest_id,
    input  logic [15:0]    cost_value,
    input  logic           last_entry,
    input  dvrt_pkg::ctl_t ctl,
    input  logic [$clog2(NODES)-1:0] idx,
    output dvrt_pkg::sts_t sts,
    output logic [1:0]     status,
    output logic [2:0]     route_next_hop,
    output logic [15:0]    route_cost,
    output logic [15:0]    packet_count,
    output logic [7:0]     timeout_mask
);
    localparam int IW = $clog2(NODES);
    localparam int HW = (IW > 3) ? IW : 3;
    localparam logic [COST_BITS-1:0] INF = {COST_BITS{1'b1}};

    logic [COST_BITS-1:0] cost_reg [NODES];
    logic [HW-1:0]        hop_reg  [NODES];
    logic [COST_BITS-1:0] vec_reg  [NODES];
    logic [3:0]           miss_reg [NODES];
    logic [NODES-1:0]     nbr_reg;
    logic                 crash_reg;
    logic [15:0]          seen_reg;
    logic [2:0]           my_id_reg;
    logic [3:0]           limit_reg;

    // latched item for sweeps
    dvrt_pkg::sweep_t     kind_reg;
    logic [HW-1:0]        tgt_reg;     // sender / dropped hop
    logic [COST_BITS-1:0] link_reg;
    logic [1:0]           st_reg, st_next;
    logic [2:0]           rh_reg, rh_next;
    logic [15:0]          rc_reg, rc_next;
    logic [15:0]          pc_reg, pc_next;
    logic [7:0]           tm_reg;

    // widened ids
    logic [HW-1:0] snd, dst, me;
    assign snd = HW'(sender_id);
    assign dst = HW'(dest_id);
    assign me  = HW'(my_id_reg);

    logic [COST_BITS-1:0] cin;
    always_comb
    begin
        if (COST_BITS >= 16)
            cin = COST_BITS'(cost_value);
        else
            cin = (cost_value > 16'(INF)) ? INF : COST_BITS'(cost_value);
    end

    function automatic logic nok(input logic [HW-1:0] id);
        return id != '0 && 32'(id) < NODES;
    endfunction

    logic me_ok, snd_peer, dst_peer, dst_node;
    assign me_ok    = nok(me);
    assign snd_peer = nok(snd) && snd != me;
    assign dst_peer = nok(dst) && dst != me;
    assign dst_node = nok(dst);

    logic vec_apply;
    assign vec_apply = cmd == dvrt_pkg::CMD_VECTOR && !crash_reg && snd_peer && dst_node
                       && last_entry;

    always_comb
    begin
        sts.need_sweep = 1'b0;
        sts.kind       = dvrt_pkg::SWP_DROP;
        case (cmd)
            dvrt_pkg::CMD_VECTOR:
            begin
                sts.need_sweep = vec_apply;
                sts.kind       = dvrt_pkg::SWP_APPLY;
            end
            dvrt_pkg::CMD_REMOTE:
                sts.need_sweep = !crash_reg && snd_peer && cin == INF;
            dvrt_pkg::CMD_LOCAL:
                sts.need_sweep = dst_peer && nbr_reg[dst[IW-1:0]] && cin == INF;
            dvrt_pkg::CMD_DIS:
                sts.need_sweep = dst_peer && nbr_reg[dst[IW-1:0]];
            dvrt_pkg::CMD_TICK:
            begin
                sts.need_sweep = 1'b1;
                sts.kind       = dvrt_pkg::SWP_TICK;
            end
            default: ;
        endcase
    end

    // result fields of the accepted beat
    always_comb
    begin
        st_next = dvrt_pkg::ST_OK;
        rh_next = '0;
        rc_next = '0;
        pc_next = '0;
        case (cmd)
            dvrt_pkg::CMD_VECTOR:
                if (crash_reg) st_next = dvrt_pkg::ST_IGNORE;
                else if (!snd_peer || !dst_node) st_next = dvrt_pkg::ST_BADID;
            dvrt_pkg::CMD_REMOTE:
                if (crash_reg) st_next = dvrt_pkg::ST_IGNORE;
                else if (!snd_peer) st_next = dvrt_pkg::ST_BADID;
            dvrt_pkg::CMD_LOCAL, dvrt_pkg::CMD_DIS:
                if (!dst_peer) st_next = dvrt_pkg::ST_BADID;
                else if (!nbr_reg[dst[IW-1:0]]) st_next = dvrt_pkg::ST_NONBR;
            dvrt_pkg::CMD_ADD:
                if (crash_reg) st_next = dvrt_pkg::ST_IGNORE;
                else if (!dst_peer) st_next = dvrt_pkg::ST_BADID;
            dvrt_pkg::CMD_CRASH, dvrt_pkg::CMD_TICK: ;
            dvrt_pkg::CMD_READ:
                if (crash_reg) st_next = dvrt_pkg::ST_IGNORE;
                else if (!dst_node) st_next = dvrt_pkg::ST_BADID;
                else if (dst == me) rh_next = my_id_reg;
                else
                begin
                    rh_next = hop_reg[dst[IW-1:0]][2:0];
                    rc_next = 16'(cost_reg[dst[IW-1:0]]);
                end
            dvrt_pkg::CMD_PKT:
                pc_next = seen_reg;
            default: st_next = dvrt_pkg::ST_IGNORE;
        endcase
    end

    // link cost for vector apply as seen with the current entry written
    logic [COST_BITS-1:0] link_now;
    always_comb
    begin
        if (!me_ok)
            link_now = INF;
        else if (me == snd)
            link_now = '0;
        else if (me == dst)
            link_now = cin;
        else
            link_now = vec_reg[me[IW-1:0]];
    end

    // per-entry sweep unit
    logic [COST_BITS:0] via_sum;
    logic [COST_BITS-1:0] via, ent;
    logic is_tgt_entry;
    assign is_tgt_entry = (HW'(idx) == tgt_reg);
    assign ent = is_tgt_entry ? '0 : vec_reg[idx];
    assign via_sum = {1'b0, link_reg} + {1'b0, ent};
    assign via = via_sum[COST_BITS] ? INF : via_sum[COST_BITS-1:0];

    logic timeout_k;
    assign timeout_k = nbr_reg[idx] && cost_reg[idx] != INF && miss_reg[idx] >= limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                cost_reg[i] <= INF;
                hop_reg[i]  <= '0;
                vec_reg[i]  <= INF;
                miss_reg[i] <= '0;
            end
            nbr_reg     <= '0;
            crash_reg   <= 1'b0;
            seen_reg    <= '0;
            my_id_reg   <= 3'd1;
            limit_reg   <= 4'd3;
            kind_reg    <= dvrt_pkg::SWP_DROP;
            tgt_reg     <= '0;
            link_reg    <= '0;
            st_reg      <= '0;
            rh_reg      <= '0;
            rc_reg      <= '0;
            pc_reg      <= '0;
            tm_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == dvrt_pkg::REG_MY_ID)
                    my_id_reg <= cfg_data[2:0];
                else
                    limit_reg <= cfg_data;
            end
            if (ctl.start)
            begin
                kind_reg    <= sts.kind;
                tgt_reg     <= (cmd == dvrt_pkg::CMD_LOCAL || cmd == dvrt_pkg::CMD_DIS)
                               ? dst : snd;
                link_reg    <= link_now;
                st_reg      <= st_next;
                rh_reg      <= rh_next;
                rc_reg      <= rc_next;
                pc_reg      <= pc_next;
                tm_reg      <= '0;
                case (cmd)
                    dvrt_pkg::CMD_VECTOR:
                        if (st_next == dvrt_pkg::ST_OK)
                        begin
                            vec_reg[dst[IW-1:0]] <= cin;
                            if (last_entry)
                            begin
                                miss_reg[snd[IW-1:0]] <= '0;
                                if (seen_reg != 16'(dvrt_pkg::COUNT_MAX))
                                    seen_reg <= seen_reg + 16'd1;
                            end
                        end
                    dvrt_pkg::CMD_REMOTE:
                        if (st_next == dvrt_pkg::ST_OK)
                        begin
                            miss_reg[snd[IW-1:0]] <= '0;
                            if (cin == INF)
                            begin
                                cost_reg[snd[IW-1:0]] <= INF;
                                hop_reg[snd[IW-1:0]]  <= '0;
                            end
                            else
                            begin
                                cost_reg[snd[IW-1:0]] <= cin;
                                hop_reg[snd[IW-1:0]]  <= snd;
                            end
                        end
                    dvrt_pkg::CMD_LOCAL:
                        if (st_next == dvrt_pkg::ST_OK)
                        begin
                            if (cin == INF)
                            begin
                                cost_reg[dst[IW-1:0]] <= INF;
                                hop_reg[dst[IW-1:0]]  <= '0;
                            end
                            else
                            begin
                                cost_reg[dst[IW-1:0]] <= cin;
                                hop_reg[dst[IW-1:0]]  <= dst;
                            end
                        end
                    dvrt_pkg::CMD_ADD:
                        if (st_next == dvrt_pkg::ST_OK)
                        begin
                            nbr_reg[dst[IW-1:0]]  <= 1'b1;
                            miss_reg[dst[IW-1:0]] <= '0;
                            cost_reg[dst[IW-1:0]] <= cin;
                            hop_reg[dst[IW-1:0]]  <= (cin == INF) ? '0 : dst;
                        end
                    dvrt_pkg::CMD_DIS:
                        if (st_next == dvrt_pkg::ST_OK)
                        begin
                            cost_reg[dst[IW-1:0]] <= INF;
                            hop_reg[dst[IW-1:0]]  <= '0;
                            nbr_reg[dst[IW-1:0]]  <= 1'b0;
                            miss_reg[dst[IW-1:0]] <= '0;
                        end
                    dvrt_pkg::CMD_CRASH:
                    begin
                        crash_reg <= 1'b1;
                        nbr_reg   <= '0;
                        for (int i = 0; i < NODES; i++)
                        begin
                            cost_reg[i] <= INF;
                            hop_reg[i]  <= '0;
                            vec_reg[i]  <= INF;
                        end
                    end
                    dvrt_pkg::CMD_PKT:
                        seen_reg <= '0;
                    default: ;
                endcase
            end
            else if (ctl.sweep && HW'(idx) != me)
            begin
                case (kind_reg)
                    dvrt_pkg::SWP_DROP:
                        if (hop_reg[idx] == tgt_reg)
                        begin
                            cost_reg[idx] <= INF;
                            hop_reg[idx]  <= '0;
                        end
                    dvrt_pkg::SWP_APPLY:
                    begin
                        if (via < cost_reg[idx])
                        begin
                            cost_reg[idx] <= via;
                            hop_reg[idx]  <= tgt_reg;
                        end
                        else if (hop_reg[idx] == tgt_reg)
                        begin
                            cost_reg[idx] <= via;
                            if (via == INF) hop_reg[idx] <= '0;
                        end
                    end
                    default:
                    begin
                        // tick: routes through a timed-out neighbor are dropped at once,
                        // so later steps already see them unreachable
                        if (timeout_k)
                        begin
                            cost_reg[idx] <= INF;
                            hop_reg[idx]  <= '0;
                            miss_reg[idx] <= '0;
                            for (int j = 1; j < NODES; j++)
                                if (HW'(j) != me && hop_reg[j] == HW'(idx)
                                    && j != 32'(idx))
                                begin
                                    cost_reg[j] <= INF;
                                    hop_reg[j]  <= '0;
                                end
                            if (32'(idx) < 8)
                                tm_reg[idx[(IW < 3 ? IW : 3)-1:0]] <= 1'b1;
                        end
                        else if (miss_reg[idx] != 4'(dvrt_pkg::MISS_MAX))
                            miss_reg[idx] <= miss_reg[idx] + 4'd1;
                    end
                endcase
            end
            if (ctl.last && kind_reg == dvrt_pkg::SWP_APPLY)
                for (int i = 0; i < NODES; i++)
                    vec_reg[i] <= INF;
        end
    end

    assign status         = st_reg;
    assign route_next_hop = rh_reg;
    assign route_cost     = rc_reg;
    assign packet_count   = pc_reg;
    assign timeout_mask   = tm_reg;

    a_self_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.sweep && me_ok) |=> $stable(cost_reg[me[IW-1:0]]))
        else $error("self route touched");
    a_buf_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.last && kind_reg == dvrt_pkg::SWP_APPLY) |=> vec_reg[0] == INF)
        else $error("vector buffer not cleared");
    a_crash_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        crash_reg |=> crash_reg)
        else $error("crash state left");
endmodule
